### rtl/tle_pkg.sv
// shared types, constants and widths of the terminal line editor
`default_nettype none
package tle_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int POS_W  = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int STEP_W = $clog2(STORE_DEPTH + 3);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;

  localparam logic REG_ESCAPE_MODE = 1'b0;
  localparam logic REG_ECHO_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    KIND_TERM = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OP_ECHO_ONLY = 3'd0,
    OP_LINE_END  = 3'd1,
    OP_BS_DEL    = 3'd2,
    OP_BS_EMPTY  = 3'd3,
    OP_ARROW     = 3'd4
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             echo;
    logic [7:0]       rx;
    logic [POS_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

endpackage
`default_nettype wire

### rtl/tle_if.sv
// handshake channels for received bytes and result items
`default_nettype none
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;
  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface
`default_nettype wire

### rtl/tle_front.sv
// front end: config registers, byte classification, editor state and line store
`default_nettype none
module tle_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_idx_i,
  input  wire logic           cfg_data_i,
  tle_in_if.sink              rx,
  output tle_pkg::cmd_t       cmd_o,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i,
  input  wire logic           line_done_i,
  input  wire tle_pkg::rd_req_t rd_req_i,
  output logic [7:0]          rd_data_o
);

  logic [7:0] line_mem [0:tle_pkg::STORE_DEPTH-1];

  logic                      esc_mode_q, echo_q;
  logic [tle_pkg::POS_W-1:0] wp_q, wp_d;
  logic                      csi_q, csi_d;
  logic [7:0]                prev_q, prev_d;
  logic                      lock_q, lock_d;

  logic       accept;
  logic       store_wr;
  logic       silent;
  logic [7:0] b;
  tle_pkg::op_e op;

  assign b      = rx.rx_byte;
  assign rx.ready = !lock_q && cmd_ready_i;
  assign accept = rx.valid && rx.ready;

  always_comb begin
    wp_d     = wp_q;
    csi_d    = csi_q;
    prev_d   = prev_q;
    store_wr = 1'b0;
    silent   = 1'b1;
    op       = tle_pkg::OP_ECHO_ONLY;
    if (wp_q >= tle_pkg::POS_W'(tle_pkg::STORE_DEPTH) || b == tle_pkg::CH_NUL ||
        b == tle_pkg::CH_LF || b == tle_pkg::CH_CR) begin
      op     = tle_pkg::OP_LINE_END;
      silent = 1'b0;
      wp_d   = '0;
      csi_d  = 1'b0;
      prev_d = '0;
    end else begin
      prev_d = b;
      priority if (b == tle_pkg::CH_BS) begin
        silent = 1'b0;
        if (wp_q != '0) begin
          op   = tle_pkg::OP_BS_DEL;
          wp_d = wp_q - tle_pkg::POS_W'(1);
        end else begin
          op   = tle_pkg::OP_BS_EMPTY;
        end
      end else if (esc_mode_q && b == tle_pkg::CH_ESC) begin
        // dropped
      end else if (esc_mode_q && b == tle_pkg::CH_LBRK && prev_q == tle_pkg::CH_ESC) begin
        csi_d = 1'b1;
      end else if (esc_mode_q && csi_q &&
                   (b == tle_pkg::CH_A || b == tle_pkg::CH_C || b == tle_pkg::CH_D)) begin
        op     = tle_pkg::OP_ARROW;
        silent = 1'b0;
        csi_d  = 1'b0;
      end else if (esc_mode_q && csi_q && b == tle_pkg::CH_B) begin
        csi_d = 1'b0;
      end else begin
        // not full here, so the write always lands
        store_wr = 1'b1;
        wp_d     = wp_q + tle_pkg::POS_W'(1);
      end
    end
  end

  assign cmd_o.op    = op;
  assign cmd_o.echo  = echo_q;
  assign cmd_o.rx    = b;
  assign cmd_o.len   = wp_q;
  assign cmd_valid_o = accept && (!silent || echo_q);

  // hold off new bytes until the back end has read the finished line
  always_comb begin
    lock_d = lock_q;
    if (line_done_i) lock_d = 1'b0;
    if (cmd_valid_o && op == tle_pkg::OP_LINE_END) lock_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_mode_q <= 1'b1;
      echo_q     <= 1'b0;
      wp_q       <= '0;
      csi_q      <= 1'b0;
      prev_q     <= '0;
      lock_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tle_pkg::REG_ESCAPE_MODE: esc_mode_q <= cfg_data_i;
          tle_pkg::REG_ECHO_ENABLE: echo_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        wp_q   <= wp_d;
        csi_q  <= csi_d;
        prev_q <= prev_d;
      end
      lock_q <= lock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && store_wr) line_mem[wp_q[tle_pkg::IDX_W-1:0]] <= b;
    if (rd_req_i.en) rd_data_o <= line_mem[rd_req_i.addr];
  end

endmodule
`default_nettype wire

### rtl/tle_queue.sv
// two-entry command queue between front and back end
`default_nettype none
module tle_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tle_pkg::cmd_t push_cmd_i,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  output tle_pkg::cmd_t      pop_cmd_o,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i
);

  tle_pkg::cmd_t slot_q [0:1];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_cmd_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule
`default_nettype wire

### rtl/tle_back.sv
// back end: expands each command into result items through an output register
`default_nettype none
module tle_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tle_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  output logic               line_done_o,
  output tle_pkg::rd_req_t   rd_req_o,
  input  wire logic [7:0]    rd_data_i,
  tle_out_if.source          res
);

  tle_pkg::cmd_t              cur_q;
  logic                       act_q;
  logic [tle_pkg::STEP_W-1:0] step_q, j;

  logic       o_valid_q, o_last_q, o_line_q;
  logic [1:0] o_kind_q;
  logic [7:0] o_val_q;

  tle_pkg::kind_e e_kind;
  logic [7:0]     e_val, arrow;
  logic           e_last, e_line;
  logic           o_load, issue;

  assign o_load = !o_valid_q || res.ready;
  assign issue  = act_q && o_load;
  assign cmd_ready_o = !act_q;

  always_comb begin
    unique case (cur_q.rx)
      tle_pkg::CH_A: arrow = tle_pkg::CH_B;
      tle_pkg::CH_C: arrow = tle_pkg::CH_D;
      default:       arrow = tle_pkg::CH_C;
    endcase
  end

  // element number step_q of the current command
  always_comb begin
    j      = step_q - tle_pkg::STEP_W'(cur_q.echo);
    e_kind = tle_pkg::KIND_TERM;
    e_val  = cur_q.rx;
    e_last = 1'b0;
    e_line = 1'b0;
    if (cur_q.echo && step_q == '0) begin
      e_last = (cur_q.op == tle_pkg::OP_ECHO_ONLY);
    end else begin
      unique case (cur_q.op)
        tle_pkg::OP_LINE_END: begin
          if (j < tle_pkg::STEP_W'(cur_q.len)) begin
            e_kind = tle_pkg::KIND_LINE;
            e_line = 1'b1;
          end else begin
            e_kind = tle_pkg::KIND_END;
            e_val  = 8'(cur_q.len);
            e_last = 1'b1;
          end
        end
        tle_pkg::OP_BS_DEL: begin
          unique case (j)
            tle_pkg::STEP_W'(0): e_val = tle_pkg::CH_ESC;
            tle_pkg::STEP_W'(1): e_val = tle_pkg::CH_LBRK;
            default: begin
              e_val  = tle_pkg::CH_P;
              e_last = 1'b1;
            end
          endcase
        end
        tle_pkg::OP_BS_EMPTY: begin
          unique case (j)
            tle_pkg::STEP_W'(0): e_val = tle_pkg::CH_SPACE;
            tle_pkg::STEP_W'(1): e_val = tle_pkg::CH_ESC;
            tle_pkg::STEP_W'(2): e_val = tle_pkg::CH_LBRK;
            default: begin
              e_val  = tle_pkg::CH_BEL;
              e_last = 1'b1;
            end
          endcase
        end
        tle_pkg::OP_ARROW: begin
          unique case (j)
            tle_pkg::STEP_W'(0), tle_pkg::STEP_W'(3): e_val = tle_pkg::CH_ESC;
            tle_pkg::STEP_W'(1), tle_pkg::STEP_W'(4): e_val = tle_pkg::CH_LBRK;
            tle_pkg::STEP_W'(2): e_val = arrow;
            default: begin
              e_val  = tle_pkg::CH_BEL;
              e_last = 1'b1;
            end
          endcase
        end
        default: e_last = 1'b1;
      endcase
    end
  end

  // line bytes come from the store's read register, in step with the output register
  assign rd_req_o.en   = issue && e_line;
  assign rd_req_o.addr = j[tle_pkg::IDX_W-1:0];
  assign line_done_o   = issue && e_last && cur_q.op == tle_pkg::OP_LINE_END;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      step_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (!act_q && cmd_valid_i) begin
        act_q  <= 1'b1;
        step_q <= '0;
      end else if (issue) begin
        if (e_last) act_q <= 1'b0;
        step_q <= step_q + tle_pkg::STEP_W'(1);
      end
      if (o_load) o_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!act_q && cmd_valid_i) cur_q <= cmd_i;
    if (issue) begin
      o_kind_q <= e_kind;
      o_val_q  <= e_val;
      o_last_q <= e_last;
      o_line_q <= e_line;
    end
  end

  assign res.valid = o_valid_q;
  assign res.kind  = o_kind_q;
  assign res.value = o_line_q ? rd_data_i : o_val_q;
  assign res.last  = o_last_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_kind_q == tle_pkg::KIND_END |-> o_last_q)
    else $error("line end marker without last flag");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q && cur_q.op == tle_pkg::OP_LINE_END |->
      step_q <= tle_pkg::STEP_W'(cur_q.len) + tle_pkg::STEP_W'(cur_q.echo))
    else $error("line dump ran past its length");

  a_done_ends_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_done_o |=> !act_q)
    else $error("command still active after line end");

endmodule
`default_nettype wire

### rtl/terminal_line_editor_top.sv
// top level of the terminal line editor
//
//   channel  dir  handshake      payload
//   rx_i     in   valid/ready    rx_byte[7:0]
//   res_o    out  valid/ready    kind[1:0] value[7:0] last
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// a received byte is taken and, if it gives output, queued as a command; the
// back end sends one result item per cycle while the output is ready: up to 7
// for edits, up to STORE_DEPTH+2 (34) for a line end, read from the line store.
// after a line end no byte is taken until the last stored byte has been read.
// reset clears the editor state and queue; the line store is not cleared.
// a stalled output holds its item while the queue takes commands until it is full.
`default_nettype none
module terminal_line_editor_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_idx_i,
  input  wire logic cfg_data_i,
  tle_in_if.sink    rx_i,
  tle_out_if.source res_o
);

  tle_pkg::cmd_t    f_cmd, q_cmd;
  logic             f_valid, f_ready, q_valid, q_ready;
  logic             line_done;
  tle_pkg::rd_req_t rd_req;
  logic [7:0]       rd_data;

  tle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx          (rx_i),
    .cmd_o       (f_cmd),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .line_done_i (line_done),
    .rd_req_i    (rd_req),
    .rd_data_o   (rd_data)
  );

  tle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (f_cmd),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_cmd_o    (q_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  tle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .line_done_o (line_done),
    .rd_req_o    (rd_req),
    .rd_data_i   (rd_data),
    .res         (res_o)
  );

endmodule
`default_nettype wire

### test/tb_top.sv
// self-checking bench for the terminal line editor, directed and random keystrokes checked against a line model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 75;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    tle_pkg::kind_e kind;
    logic [7:0]     value;
    logic           last;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic cfg_data_i;

  tle_in_if  rx_ch ();
  tle_out_if res_ch ();

  terminal_line_editor_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_ch),
    .res_o      (res_ch)
  );

  // line model state and its copy of the registers
  logic [7:0]                line_buf [tle_pkg::STORE_DEPTH];
  logic [tle_pkg::POS_W-1:0] fill_cnt;
  logic                      csi_seen;
  logic [7:0]                last_rx;
  logic                      esc_on;
  logic                      echo_on;

  result_t    step_results[$];
  result_t    pending_results[$];
  logic [7:0] rx_queue[$];
  logic [7:0] cursor_keys[4] = '{tle_pkg::CH_A, tle_pkg::CH_B, tle_pkg::CH_C, tle_pkg::CH_D};

  int   queued_cnt   = 0;
  int   accepted_cnt = 0;
  int   err_cnt      = 0;
  int   cycle_cnt    = 0;
  logic rx_fired     = 1'b0;

  int         burst_left   = 1;
  int         gap_left     = 0;
  int         hold_left    = 0;
  int         next_hold_at = 60;
  logic [15:0] stall_pat   = '1;
  logic [6:0]  pat_age     = '0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void push_result(tle_pkg::kind_e k, logic [7:0] v);
    result_t r;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void push_csi(logic [7:0] c);
    push_result(tle_pkg::KIND_TERM, tle_pkg::CH_ESC);
    push_result(tle_pkg::KIND_TERM, tle_pkg::CH_LBRK);
    push_result(tle_pkg::KIND_TERM, c);
  endfunction

  // works out every result item that one received byte causes
  function automatic void edit_line(logic [7:0] b);
    logic consumed;
    consumed = 1'b0;
    step_results.delete();
    if (echo_on) push_result(tle_pkg::KIND_TERM, b);
    if (fill_cnt >= tle_pkg::STORE_DEPTH || b == tle_pkg::CH_NUL || b == tle_pkg::CH_LF ||
        b == tle_pkg::CH_CR) begin
      // full store drops the byte but still ends the line
      for (int i = 0; i < fill_cnt; i++) push_result(tle_pkg::KIND_LINE, line_buf[i]);
      push_result(tle_pkg::KIND_END, 8'(fill_cnt));
      fill_cnt = '0;
      csi_seen = 1'b0;
      last_rx  = 8'h00;
    end else begin
      if (b == tle_pkg::CH_BS) begin
        if (fill_cnt != 0) begin
          push_csi(tle_pkg::CH_P);
          fill_cnt = fill_cnt - tle_pkg::POS_W'(1);
        end else begin
          push_result(tle_pkg::KIND_TERM, tle_pkg::CH_SPACE);
          push_csi(tle_pkg::CH_BEL);
        end
        consumed = 1'b1;
      end else if (esc_on) begin
        if (b == tle_pkg::CH_ESC) begin
          consumed = 1'b1;
        end else if (b == tle_pkg::CH_LBRK && last_rx == tle_pkg::CH_ESC) begin
          csi_seen = 1'b1;
          consumed = 1'b1;
        end else if (csi_seen &&
                     (b == tle_pkg::CH_A || b == tle_pkg::CH_C || b == tle_pkg::CH_D)) begin
          // answer with the opposite arrow
          push_csi(b == tle_pkg::CH_A ? tle_pkg::CH_B :
                   (b == tle_pkg::CH_C ? tle_pkg::CH_D : tle_pkg::CH_C));
          push_csi(tle_pkg::CH_BEL);
          csi_seen = 1'b0;
          consumed = 1'b1;
        end else if (csi_seen && b == tle_pkg::CH_B) begin
          csi_seen = 1'b0;
          consumed = 1'b1;
        end
      end
      if (!consumed) begin
        line_buf[fill_cnt[tle_pkg::IDX_W-1:0]] = b;
        fill_cnt = fill_cnt + tle_pkg::POS_W'(1);
      end
      last_rx = b;
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%t %s", $realtime, msg);
  endtask

  // result checking and prediction of accepted bytes
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      rx_fired <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind  = tle_pkg::kind_e'(res_ch.kind);
        got.value = res_ch.value;
        got.last  = res_ch.last;
        if (pending_results.size() == 0) begin
          note_error($sformatf("unexpected item: kind %0d value %02h last %0d",
                               got.kind, got.value, got.last));
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.value !== want.value || got.last !== want.last)
            note_error($sformatf({"mismatch: expected kind %0d value %02h last %0d, ",
                                  "got kind %0d value %02h last %0d"},
                                 want.kind, want.value, want.last,
                                 got.kind, got.value, got.last));
        end
      end
      rx_fired <= rx_ch.valid && rx_ch.ready;
      if (rx_ch.valid && rx_ch.ready) begin
        edit_line(rx_ch.rx_byte);
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // byte sender: bursts of random length with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_fired) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        rx_ch.valid <= 1'b0;
      end else if (rx_queue.size() != 0) begin
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= rx_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern, reloaded whenever its 7-bit age counter wraps, plus long hold-offs
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (accepted_cnt >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 170;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= stall_pat[0];
      pat_age      <= pat_age + 7'd1;
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat <= '1;
          1:       stall_pat <= 16'($urandom);
          2:       stall_pat <= 16'($urandom) | 16'($urandom);
          default: stall_pat <= 16'($urandom) & 16'($urandom) | 16'h0001;
        endcase
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic void queue_byte(logic [7:0] b);
    rx_queue.push_back(b);
    queued_cnt++;
  endfunction

  function automatic logic [7:0] text_char();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // one keystroke sequence: a line with cursor keys, a store fill, an escape sequence, backspaces or noise
  function automatic void queue_sequence();
    int roll;
    int len;
    int pick;
    logic [7:0] enders[3];
    enders = '{tle_pkg::CH_NUL, tle_pkg::CH_LF, tle_pkg::CH_CR};
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      len = $urandom_range(0, 30);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
          queue_byte(tle_pkg::CH_BS);
        end else if (pick == 1) begin
          queue_byte(tle_pkg::CH_ESC);
          queue_byte(tle_pkg::CH_LBRK);
          queue_byte(cursor_keys[$urandom_range(0, 3)]);
        end else begin
          queue_byte(text_char());
        end
      end
      queue_byte(enders[$urandom_range(0, 2)]);
    end else if (roll < 50) begin
      // fill the store, then one byte that gets dropped
      repeat (tle_pkg::STORE_DEPTH) queue_byte(text_char());
      queue_byte(8'($urandom_range(0, 255)));
    end else if (roll < 75) begin
      queue_byte(tle_pkg::CH_ESC);
      if ($urandom_range(0, 4) != 0) queue_byte(tle_pkg::CH_LBRK);
      if ($urandom_range(0, 4) != 0) queue_byte(cursor_keys[$urandom_range(0, 3)]);
      else queue_byte(8'($urandom_range(0, 255)));
    end else if (roll < 87) begin
      repeat ($urandom_range(1, 4)) queue_byte(tle_pkg::CH_BS);
    end else begin
      repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic write_reg(logic idx, logic val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    if (idx == tle_pkg::REG_ESCAPE_MODE) esc_on = val;
    else echo_on = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // wait until every byte is taken and every result has come, then let the block settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (rx_queue.size() != 0 || rx_ch.valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] directed[25];
    logic       esc_set[4];
    logic       echo_set[4];
    int         target;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = tle_pkg::REG_ESCAPE_MODE;
    cfg_data_i    = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready  = 1'b0;
    fill_cnt      = '0;
    csi_seen      = 1'b0;
    last_rx       = 8'h00;
    esc_on        = 1'b1;
    echo_on       = 1'b0;
    directed = '{tle_pkg::CH_BS, 8'h78, 8'hFF, tle_pkg::CH_BS,
                 tle_pkg::CH_ESC, tle_pkg::CH_LBRK, tle_pkg::CH_A,
                 tle_pkg::CH_ESC, tle_pkg::CH_LBRK, tle_pkg::CH_B,
                 tle_pkg::CH_ESC, tle_pkg::CH_LBRK, tle_pkg::CH_C,
                 tle_pkg::CH_ESC, tle_pkg::CH_LBRK, tle_pkg::CH_D,
                 tle_pkg::CH_LBRK, tle_pkg::CH_A, 8'h80, tle_pkg::CH_CR,
                 tle_pkg::CH_LF, tle_pkg::CH_NUL, 8'h7F, 8'h01, tle_pkg::CH_LF};
    esc_set  = '{1'b1, 1'b0, 1'b0, 1'b1};
    echo_set = '{1'b1, 1'b1, 1'b0, 1'b0};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(tle_pkg::REG_ESCAPE_MODE, 1'b1);
    write_reg(tle_pkg::REG_ECHO_ENABLE, 1'b0);
    foreach (directed[i]) queue_byte(directed[i]);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      write_reg(tle_pkg::REG_ESCAPE_MODE, esc_set[p]);
      write_reg(tle_pkg::REG_ECHO_ENABLE, echo_set[p]);
      target = queued_cnt + PHASE_ITEMS;
      while (queued_cnt < target) queue_sequence();
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
